// ----- rtl/brhs_pkg.sv -----
// Shared types and constants for the boundary reflect heading step block.
`timescale 1ns / 1ps
`default_nettype none

package brhs_pkg;

  localparam int HEAD_W  = 16;
  localparam int RND_W   = 16;
  localparam int POS_W   = 32;
  localparam int VEL_W   = 24;
  localparam int KG_W    = 30;
  localparam int PROD_W  = VEL_W + KG_W;   // velocity times gain, unsigned
  localparam int VEC_W   = PROD_W + 3;     // signed vector with room for CORDIC growth
  localparam int FRAC_SH = 30;             // gain is Q30
  localparam int DELTA_W = VEC_W - FRAC_SH;
  localparam int TAB_N   = 24;

  // Limit CORDIC gain compensation, Q30.
  localparam logic [KG_W-1:0] KGAIN_Q30 = KG_W'(652032874);

  // Heading faces away from the wall; binary angle, 65536 is a full turn.
  localparam logic [HEAD_W-1:0] BASE_EAST    = 16'd32768;
  localparam logic [HEAD_W-1:0] BASE_WEST    = 16'd0;
  localparam logic [HEAD_W-1:0] BASE_NORTH   = 16'd49152;
  localparam logic [HEAD_W-1:0] BASE_SOUTH   = 16'd16384;
  localparam logic [HEAD_W-1:0] MINUS_QUARTER = 16'd49152;

  typedef enum logic [2:0] {
    WALL_NONE  = 3'd0,
    WALL_EAST  = 3'd1,
    WALL_WEST  = 3'd2,
    WALL_NORTH = 3'd3,
    WALL_SOUTH = 3'd4
  } wall_t;

  // Configuration register indexes (word address).
  localparam logic REG_VELOCITY = 1'b0;

  localparam logic [VEL_W-1:0] VELOCITY_RESET = 24'd65536;

  // atan(2^-i) in 2^-32 turn units.
  localparam logic [31:0] ATAN_TURNS32 [TAB_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic [2:0]             wall_hit;
    logic [RND_W-1:0]       random_fraction;
    logic [HEAD_W-1:0]      heading_in;
    logic signed [POS_W-1:0] pos_x_in;
    logic signed [POS_W-1:0] pos_y_in;
  } agent_t;

  typedef struct packed {
    logic [HEAD_W-1:0]       heading_out;
    logic signed [POS_W-1:0] pos_x_out;
    logic signed [POS_W-1:0] pos_y_out;
    logic                    saturated;
  } step_t;

  // Fields that ride along the rotation pipeline untouched.
  typedef struct packed {
    logic [HEAD_W-1:0]       heading;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/brhs_cordic_stage.sv -----
// One registered micro-rotation of the rotation-mode CORDIC.
`timescale 1ns / 1ps
`default_nettype none

module brhs_cordic_stage
  import brhs_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int ANGLE_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          load,
  input  wire                          valid_in,
  input  side_t                        side_in,
  input  wire signed [VEC_W-1:0]       x_in,
  input  wire signed [VEC_W-1:0]       y_in,
  input  wire signed [ANGLE_BITS-1:0]  z_in,
  output logic                         valid,
  output side_t                        side,
  output logic signed [VEC_W-1:0]      x,
  output logic signed [VEC_W-1:0]      y,
  output logic signed [ANGLE_BITS-1:0] z
);

  localparam logic signed [ANGLE_BITS-1:0] T =
    ANGLE_BITS'(ATAN_TURNS32[IDX] >> (32 - ANGLE_BITS));

  logic signed [VEC_W-1:0]      xs;
  logic signed [VEC_W-1:0]      ys;
  logic signed [VEC_W-1:0]      x_next;
  logic signed [VEC_W-1:0]      y_next;
  logic signed [ANGLE_BITS-1:0] z_next;

  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!z_in[ANGLE_BITS-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - T;
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + T;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side <= side_in;
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/boundary_reflect_heading_step.sv -----
// Top level of the boundary reflect heading step: heading update, CORDIC step, saturation.
`timescale 1ns / 1ps
`default_nettype none

// Each agent item gets a new heading facing away from the wall it hit (east,
// west, north or south) plus a random offset of up to a quarter turn either
// way; wall code zero or an unknown code keeps the heading. The position then
// moves by velocity times cos and sin of the heading, computed by a pipelined
// rotation-mode CORDIC, and each coordinate clamps to the signed 32-bit range,
// with saturated flagging any clamp. The block takes one item per clock unless
// the pipeline is full under a stalled output, and returns one result item per
// input item in order. It has one stage for the heading update and the
// velocity-times-gain multiply, one for the quadrant pre-rotation, one per
// CORDIC micro-rotation, one for rounding and one for the add and clamp. Each
// stage has its own valid bit and advances whenever the stage after it is
// empty or moving, so bubbles close up under a stalled output and an item can
// still be taken while a finished result waits. Velocity is written through
// the APB port at byte address 0 (reset value 1.0 in Q8.16); write it only
// while the pipeline is empty.
module boundary_reflect_heading_step
  import brhs_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  wire         clk,
  input  wire         rst,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // agent items in
  input  wire         agent_valid,
  output logic        agent_ready,
  input  agent_t      agent,
  // result items out
  output logic        step_valid,
  input  wire         step_ready,
  output step_t       step
);

  localparam int N = CORDIC_STAGES;
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
  localparam logic signed [VEC_W-1:0] ROUND_HALF = VEC_W'(1) << (FRAC_SH - 1);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [VEL_W-1:0] velocity;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity <= VELOCITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_VELOCITY) begin
      velocity <= pwdata[VEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_VELOCITY) begin
      prdata = 32'(velocity);
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables: a slot loads when it is empty or the slot after it loads
  // ---------------------------------------------------------------------
  logic sa_valid, sb_valid, sr_valid;
  logic sa_en, sb_en, sr_en, out_en;
  logic rdy [1:N];

  logic                          c_valid [0:N];
  side_t                         c_side  [0:N];
  logic signed [VEC_W-1:0]       c_x     [0:N];
  logic signed [VEC_W-1:0]       c_y     [0:N];
  logic signed [ANGLE_BITS-1:0]  c_z     [0:N];

  assign out_en = !step_valid || step_ready;
  assign sr_en  = !sr_valid || out_en;
  assign rdy[N] = !c_valid[N] || sr_en;

  for (genvar j = 1; j < N; j++) begin : g_rdy
    assign rdy[j] = !c_valid[j] || rdy[j+1];
  end

  assign sb_en       = !sb_valid || rdy[1];
  assign sa_en       = !sa_valid || sb_en;
  assign agent_ready = sa_en;

  // ---------------------------------------------------------------------
  // Stage A: new heading, angle split, velocity times gain
  // ---------------------------------------------------------------------
  logic [HEAD_W-1:0]            head_next;
  logic [HEAD_W-1:0]            base;
  logic                         turn;
  logic [ANGLE_BITS+HEAD_W-1:0] a_wide;
  logic [ANGLE_BITS-1:0]        a_scaled;
  logic [ANGLE_BITS-1:0]        a_shift;
  logic [1:0]                   q_next;
  logic signed [ANGLE_BITS-1:0] z_next;

  side_t                        sa_side;
  logic [1:0]                   sa_q;
  logic signed [ANGLE_BITS-1:0] sa_z;
  logic [PROD_W-1:0]            sa_v0;

  always_comb begin
    base = BASE_WEST;
    turn = 1'b1;
    case (wall_t'(agent.wall_hit))
      WALL_EAST:  base = BASE_EAST;
      WALL_WEST:  base = BASE_WEST;
      WALL_NORTH: base = BASE_NORTH;
      WALL_SOUTH: base = BASE_SOUTH;
      default:    turn = 1'b0;
    endcase
    head_next = agent.heading_in;
    if (turn) begin
      head_next = base + MINUS_QUARTER + {1'b0, agent.random_fraction[RND_W-1:1]};
    end
    // Rescale the binary angle to ANGLE_BITS (truncate when narrowing).
    a_wide   = {head_next, {ANGLE_BITS{1'b0}}};
    a_scaled = a_wide[ANGLE_BITS+HEAD_W-1:HEAD_W];
    // Nearest quarter turn plus residual in [-1/8, 1/8) turn.
    a_shift  = a_scaled + EIGHTH;
    q_next   = a_shift[ANGLE_BITS-1:ANGLE_BITS-2];
    z_next   = $signed({2'b00, a_shift[ANGLE_BITS-3:0]}) - $signed(EIGHTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (sa_en) begin
      sa_valid <= agent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_en) begin
      sa_side.heading <= head_next;
      sa_side.pos_x   <= agent.pos_x_in;
      sa_side.pos_y   <= agent.pos_y_in;
      sa_q            <= q_next;
      sa_z            <= z_next;
      sa_v0           <= PROD_W'(velocity) * PROD_W'(KGAIN_Q30);
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: apply the quarter turn exactly
  // ---------------------------------------------------------------------
  logic signed [VEC_W-1:0]      v0s;
  logic signed [VEC_W-1:0]      x0_next;
  logic signed [VEC_W-1:0]      y0_next;
  side_t                        sb_side;
  logic signed [VEC_W-1:0]      sb_x;
  logic signed [VEC_W-1:0]      sb_y;
  logic signed [ANGLE_BITS-1:0] sb_z;

  always_comb begin
    v0s = VEC_W'($signed({1'b0, sa_v0}));
    case (sa_q)
      2'd0: begin
        x0_next = v0s;
        y0_next = '0;
      end
      2'd1: begin
        x0_next = '0;
        y0_next = v0s;
      end
      2'd2: begin
        x0_next = -v0s;
        y0_next = '0;
      end
      default: begin
        x0_next = '0;
        y0_next = -v0s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (sb_en) begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_en) begin
      sb_side <= sa_side;
      sb_x    <= x0_next;
      sb_y    <= y0_next;
      sb_z    <= sa_z;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC micro-rotations, one register stage each
  // ---------------------------------------------------------------------
  assign c_valid[0] = sb_valid;
  assign c_side[0]  = sb_side;
  assign c_x[0]     = sb_x;
  assign c_y[0]     = sb_y;
  assign c_z[0]     = sb_z;

  for (genvar k = 0; k < N; k++) begin : g_cordic
    brhs_cordic_stage #(
      .IDX        (k),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .load     (rdy[k+1]),
      .valid_in (c_valid[k]),
      .side_in  (c_side[k]),
      .x_in     (c_x[k]),
      .y_in     (c_y[k]),
      .z_in     (c_z[k]),
      .valid    (c_valid[k+1]),
      .side     (c_side[k+1]),
      .x        (c_x[k+1]),
      .y        (c_y[k+1]),
      .z        (c_z[k+1])
    );
  end

  // The residual angle is spent; its last value is not needed.
  // ---------------------------------------------------------------------
  // Stage R: drop the Q30 gain scale, round half up
  // ---------------------------------------------------------------------
  logic signed [VEC_W-1:0]   xr;
  logic signed [VEC_W-1:0]   yr;
  side_t                     sr_side;
  logic signed [DELTA_W-1:0] sr_dx;
  logic signed [DELTA_W-1:0] sr_dy;

  assign xr = c_x[N] + ROUND_HALF;
  assign yr = c_y[N] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_valid <= 1'b0;
    end else if (sr_en) begin
      sr_valid <= c_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (sr_en) begin
      sr_side <= c_side[N];
      sr_dx   <= xr[VEC_W-1:FRAC_SH];
      sr_dy   <= yr[VEC_W-1:FRAC_SH];
    end
  end

  // ---------------------------------------------------------------------
  // Stage S: advance the position and clamp to the signed 32-bit range
  // ---------------------------------------------------------------------
  logic signed [POS_W:0]   sum_x;
  logic signed [POS_W:0]   sum_y;
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic                    clamp_x;
  logic                    clamp_y;

  always_comb begin
    sum_x   = (POS_W+1)'(sr_side.pos_x) + (POS_W+1)'(sr_dx);
    sum_y   = (POS_W+1)'(sr_side.pos_y) + (POS_W+1)'(sr_dy);
    clamp_x = sum_x[POS_W] != sum_x[POS_W-1];
    clamp_y = sum_y[POS_W] != sum_y[POS_W-1];
    nx      = sum_x[POS_W-1:0];
    ny      = sum_y[POS_W-1:0];
    if (clamp_x) begin
      nx = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    if (clamp_y) begin
      ny = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (out_en) begin
      step_valid <= sr_valid;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (out_en) begin
      step.heading_out <= sr_side.heading;
      step.pos_x_out   <= nx;
      step.pos_y_out   <= ny;
      step.saturated   <= clamp_x || clamp_y;
    end
  end

endmodule

`default_nettype wire
